### rtl/mac_learning_table_assert.svh
// Assertion macros for the MAC learning table.
// Used by the top level only; clocked on clk_i, disabled while rst_ni is low.
`ifndef MAC_LEARNING_TABLE_ASSERT_SVH
`define MAC_LEARNING_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define MLT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mac_learning_table assertion failed");
`define MLT_ASSERT_NEVER(lbl, cond) \
  `MLT_ASSERT(lbl, !(cond))
`else
`define MLT_ASSERT(lbl, prop)
`define MLT_ASSERT_NEVER(lbl, cond)
`endif
`endif

### rtl/mlt_pkg.sv
// Shared types and codes of the MAC learning table.
// No dependencies; used by mlt_cell and mac_learning_table.
package mlt_pkg;

  localparam int unsigned MacW     = 48;
  localparam int unsigned PortW    = 6;
  localparam int unsigned OutIdxW  = 6;
  localparam int unsigned OutcomeW = 2;

  localparam logic [OutcomeW-1:0] OUTCOME_UPDATED  = 2'd0;
  localparam logic [OutcomeW-1:0] OUTCOME_INSERTED = 2'd1;
  localparam logic [OutcomeW-1:0] OUTCOME_FULL     = 2'd2;

  // search token flags passed from cell to cell
  typedef struct packed {
    logic vld;
    logic hit;
    logic free;
  } tok_flags_t;

  // table write command broadcast to all cells
  typedef struct packed {
    logic en;
    logic insert;
  } wr_cmd_t;

endpackage

### rtl/mlt_cell.sv
// One table entry plus one stage of the search chain.
// Depends on mlt_pkg.
module mlt_cell #(
  parameter int unsigned IdxW    = 6,
  parameter int unsigned CellIdx = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [mlt_pkg::MacW-1:0]  key_mac_i,
  input  logic [mlt_pkg::PortW-1:0] key_port_i,
  input  mlt_pkg::wr_cmd_t          wr_i,
  input  logic [IdxW-1:0]           wr_idx_i,
  input  mlt_pkg::tok_flags_t       tok_i,
  input  logic [IdxW-1:0]           tok_hit_idx_i,
  input  logic [IdxW-1:0]           tok_free_idx_i,
  output mlt_pkg::tok_flags_t       tok_o,
  output logic [IdxW-1:0]           tok_hit_idx_o,
  output logic [IdxW-1:0]           tok_free_idx_o
);

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CellIdx);

  logic                      valid_q;
  logic [mlt_pkg::MacW-1:0]  mac_q;
  logic [mlt_pkg::PortW-1:0] port_q;

  mlt_pkg::tok_flags_t tok_d, tok_q;
  logic [IdxW-1:0]     hit_idx_d, hit_idx_q;
  logic [IdxW-1:0]     free_idx_d, free_idx_q;

  logic match, sel;

  assign match = valid_q && (mac_q == key_mac_i);
  assign sel   = wr_i.en && (wr_idx_i == MyIdx);

  always_comb begin
    tok_d.vld  = tok_i.vld;
    tok_d.hit  = tok_i.hit | match;
    tok_d.free = tok_i.free | !valid_q;
    hit_idx_d  = tok_i.hit ? tok_hit_idx_i : MyIdx;
    free_idx_d = tok_i.free ? tok_free_idx_i : MyIdx;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      tok_q <= tok_d;
      if (sel && wr_i.insert) begin
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    if (sel) begin
      port_q <= key_port_i;
      if (wr_i.insert) begin
        mac_q <= key_mac_i;
      end
    end
  end

  assign tok_o          = tok_q;
  assign tok_hit_idx_o  = hit_idx_q;
  assign tok_free_idx_o = free_idx_q;

endmodule

### rtl/mac_learning_table.sv
// Top level of the MAC learning table: key registers, cell chain, result logic.
// Depends on mlt_pkg, mlt_cell and mac_learning_table_assert.svh.
//
// Usage:
//   A learn request (mac_address_i, port_number_i) is transferred at a rising
//   edge with start_i high and busy_o low. busy_o then stays high while a search
//   token walks the chain of cells, one entry per cycle, collecting the first
//   matching entry and the lowest free entry.
//   When the token leaves the last cell the table is written (port update or
//   insert) and the result appears on outcome_o / entry_index_o with done_o high
//   for exactly one cycle. The receiver cannot stall; the result is transferred
//   at the edge ending that cycle.
//   Between the start transfer and done_o lie go_q, the token register of every
//   cell and done_q. The table takes no new request while a token is in the
//   chain; busy_o falls as done_o rises.
//   Reset clears all valid bits at once; no clearing pass is needed. Entry
//   index reports the low 6 bits of the entry number; it is zero when full.
module mac_learning_table #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [mlt_pkg::MacW-1:0]          mac_address_i,
  input  logic [mlt_pkg::PortW-1:0]         port_number_i,
  output logic                              done_o,
  output logic [mlt_pkg::OutcomeW-1:0]      outcome_o,
  output logic [mlt_pkg::OutIdxW-1:0]       entry_index_o
);

  localparam int unsigned IdxW = $clog2(TABLE_ENTRIES);
  localparam int unsigned ExtW = IdxW + mlt_pkg::OutIdxW;

  logic                      busy_q, go_q, done_q;
  logic [mlt_pkg::MacW-1:0]  key_mac_q;
  logic [mlt_pkg::PortW-1:0] key_port_q;
  logic [mlt_pkg::OutcomeW-1:0] outcome_d, outcome_q;
  logic [mlt_pkg::OutIdxW-1:0]  entry_index_d, entry_index_q;

  mlt_pkg::tok_flags_t tok_f        [TABLE_ENTRIES+1];
  logic [IdxW-1:0]     tok_hit_idx  [TABLE_ENTRIES+1];
  logic [IdxW-1:0]     tok_free_idx [TABLE_ENTRIES+1];
  logic [TABLE_ENTRIES-1:0] tok_vld;

  mlt_pkg::tok_flags_t last;
  mlt_pkg::wr_cmd_t    wr;
  logic [IdxW-1:0]     wr_idx;
  logic [ExtW-1:0]     idx_ext;
  logic                accept;

  assign accept = start_i && !busy_q;

  assign tok_f[0].vld     = go_q;
  assign tok_f[0].hit     = 1'b0;
  assign tok_f[0].free    = 1'b0;
  assign tok_hit_idx[0]   = '0;
  assign tok_free_idx[0]  = '0;

  for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
    mlt_cell #(
      .IdxW    (IdxW),
      .CellIdx (k)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .key_mac_i      (key_mac_q),
      .key_port_i     (key_port_q),
      .wr_i           (wr),
      .wr_idx_i       (wr_idx),
      .tok_i          (tok_f[k]),
      .tok_hit_idx_i  (tok_hit_idx[k]),
      .tok_free_idx_i (tok_free_idx[k]),
      .tok_o          (tok_f[k+1]),
      .tok_hit_idx_o  (tok_hit_idx[k+1]),
      .tok_free_idx_o (tok_free_idx[k+1])
    );
    assign tok_vld[k] = tok_f[k+1].vld;
  end

  assign last = tok_f[TABLE_ENTRIES];

  always_comb begin
    wr.en     = last.vld && (last.hit || last.free);
    wr.insert = !last.hit;
    if (last.hit) begin
      wr_idx    = tok_hit_idx[TABLE_ENTRIES];
      outcome_d = mlt_pkg::OUTCOME_UPDATED;
    end else if (last.free) begin
      wr_idx    = tok_free_idx[TABLE_ENTRIES];
      outcome_d = mlt_pkg::OUTCOME_INSERTED;
    end else begin
      wr_idx    = '0;
      outcome_d = mlt_pkg::OUTCOME_FULL;
    end
    idx_ext       = ExtW'(wr_idx);
    entry_index_d = idx_ext[mlt_pkg::OutIdxW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      go_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      go_q   <= accept;
      done_q <= last.vld;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (last.vld) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_mac_q  <= mac_address_i;
      key_port_q <= port_number_i;
    end
    if (last.vld) begin
      outcome_q     <= outcome_d;
      entry_index_q <= entry_index_d;
    end
  end

  assign busy_o        = busy_q;
  assign done_o        = done_q;
  assign outcome_o     = outcome_q;
  assign entry_index_o = entry_index_q;

`include "mac_learning_table_assert.svh"

  `MLT_ASSERT(a_busy_after_start, accept |=> busy_o)
  `MLT_ASSERT_NEVER(a_done_while_busy, done_o && busy_o)
  `MLT_ASSERT(a_single_token, $onehot0({go_q, tok_vld}))
  `MLT_ASSERT(a_full_index_zero, (done_o && outcome_o == mlt_pkg::OUTCOME_FULL) |-> (entry_index_o == '0))

endmodule
